@@ hw/rtl/fp32_to_fp8_encoder_macros.svh @@
// Assertion macros for the fp32 to fp8 encoder checker
`ifndef FP32_TO_FP8_ENCODER_MACROS_SVH
`define FP32_TO_FP8_ENCODER_MACROS_SVH

// Assert a property on clk, disabled while reset is asserted
`define F8E_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Assert that a condition is followed in the next cycle by another
`define F8E_NEXT(label, cond, res, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (res)) \
		else $error(msg);

`endif

@@ hw/rtl/f8e_pkg.sv @@
// Package: format codes, special codes and the encode functions
package f8e_pkg;

	typedef enum logic [1:0] {
		FMT_E4M3 = 2'd0,
		FMT_E5M2 = 2'd1,
		FMT_E8M0 = 2'd2,
		FMT_NONE = 2'd3
	} fmt_t;

	localparam logic [7:0] CODE_NAN      = 8'h7F;
	localparam logic [6:0] INF_E4M3      = 7'h7E;
	localparam logic [6:0] INF_E5M2      = 7'h7C;
	localparam logic [22:0] SQRT2_FRAC   = 23'h3504F3;

	// E4M3 / E5M2 encode; mantissa width 3 or 2
	function automatic logic [7:0] enc_small(input logic s, input logic [7:0] e,
			input logic [22:0] m, input logic e4);
		logic [23:0] sig;
		logic [7:0]  min_norm, min_sub, max_e;
		logic [22:0] max_m;
		logic [6:0]  infc;
		logic [4:0]  sh;
		logic [24:0] q;
		logic [3:0]  mmax;
		logic [7:0]  ef;
		logic [6:0]  r;
		sig      = {1'b1, m};
		min_norm = e4 ? 8'd121 : 8'd113;
		min_sub  = e4 ? 8'd118 : 8'd111;
		max_e    = e4 ? 8'd134 : 8'd142;
		max_m    = e4 ? 23'h700000 : 23'h600000;
		infc     = e4 ? INF_E4M3 : INF_E5M2;
		mmax     = e4 ? 4'd7 : 4'd3;
		r        = 7'd0;
		if (e == 8'hFF) begin
			return (m != 23'd0) ? CODE_NAN : {s, infc};
		end
		if (e < min_sub) begin
			return {s, 7'd0};
		end
		if (e > max_e || (e == max_e && m > max_m)) begin
			return {s, infc};
		end
		if (e < min_norm) begin
			sh = 5'd23 - 5'(e - min_sub);
			q  = ({1'b0, sig} + (25'd1 << (sh - 5'd1))) >> sh;
			if (q == 25'd0) q = 25'd1;
			if (q > 25'(mmax)) q = 25'(mmax);
			r = 7'(q);
		end else begin
			ef = e - 8'd127 + (e4 ? 8'd7 : 8'd15);
			sh = e4 ? 5'd20 : 5'd21;
			q  = ({2'b0, m} + (25'd1 << (sh - 5'd1))) >> sh;
			if (q > 25'(mmax)) q = 25'(mmax);
			r = e4 ? {ef[3:0], q[2:0]} : {ef[4:0], q[1:0]};
		end
		return {s, r};
	endfunction

	function automatic logic [7:0] enc_e8m0(input logic s, input logic [7:0] e,
			input logic [22:0] m);
		logic [6:0] ef;
		if (e == 8'hFF) return (m != 23'd0) ? 8'd0 : {s, 7'd0};
		if (e < 8'd64) return {s, 7'd0};
		if (e >= 8'd190) return {s, 7'd126};
		ef = 7'(e - 8'd64);
		if (m > SQRT2_FRAC) ef = ef + 7'd1;
		return {s, ef};
	endfunction

endpackage

@@ hw/rtl/f8e_core.sv @@
// Combinational encode of one fp32 pattern into an 8-bit code
module f8e_core import f8e_pkg::*; (
	input  logic [31:0] value_bits,
	input  logic [1:0]  fmt,
	output logic [7:0]  code
);
	always_comb begin
		case (fmt)
			FMT_E4M3: code = enc_small(value_bits[31], value_bits[30:23], value_bits[22:0], 1'b1);
			FMT_E5M2: code = enc_small(value_bits[31], value_bits[30:23], value_bits[22:0], 1'b0);
			FMT_E8M0: code = enc_e8m0(value_bits[31], value_bits[30:23], value_bits[22:0]);
			default:  code = 8'd0;
		endcase
	end
endmodule

@@ hw/rtl/fp32_to_fp8_encoder.sv @@
// Top level: fp32 to fp8 (E4M3 / E5M2 / E8M0) encoder
//  channel   | ports                      | handshake
//  input     | start, value_bits          | transfer when start && !busy
//  result    | done, code                 | transfer every cycle done is high
//  config    | target_format_we, _wdata   | write when we is high
// done is registered through the input register and then the result register after an input transfer.
// Rate: one item per cycle; the encode logic sits between the two registers.
// busy is always low: nothing holds an item back.
// Reset clears the format register to E4M3 and both valid flags.
module fp32_to_fp8_encoder import f8e_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] value_bits,
	input  logic        target_format_we,
	input  logic [1:0]  target_format_wdata,
	output logic        done,
	output logic [7:0]  code
);
	logic [1:0]  fmt_q;
	logic        vld_s1;
	logic [31:0] val_s1;
	logic [7:0]  enc;
	logic        vld_s2;
	logic [7:0]  code_s2;

	assign busy = 1'b0;

	// hold the format between writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_E4M3;
		end else if (target_format_we) begin
			fmt_q <= target_format_wdata;
		end
	end

	// stage valids advance every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start) begin
			val_s1 <= value_bits;
		end
		if (vld_s1) begin
			code_s2 <= enc;
		end
	end

	f8e_core u_core (
		.value_bits (val_s1),
		.fmt        (fmt_q),
		.code       (enc)
	);

	assign done = vld_s2;
	assign code = code_s2;
endmodule

@@ hw/rtl/f8e_checker.sv @@
// Port-level checker for the encoder, bound to the top level
`include "fp32_to_fp8_encoder_macros.svh"
module f8e_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [31:0] value_bits,
	input logic        done,
	input logic [7:0]  code
);
	`F8E_ASSERT(a_never_busy, !busy, "busy raised")
	`F8E_NEXT(a_done_follows, start && !busy, ##1 done, "missing result")
	`F8E_NEXT(a_no_spurious, !start, ##1 !done, "result without transfer")
	`F8E_NEXT(a_nan_code, start && value_bits[30:23] == 8'hFF && value_bits[22:0] != 23'd0,
		##1 (code == 8'h7F || code == 8'h00), "bad NaN code")
endmodule

bind fp32_to_fp8_encoder f8e_checker u_f8e_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.value_bits(value_bits), .done(done), .code(code)
);

@@ tb/tb_fp32_to_fp8_encoder.sv @@
// Testbench for the fp32 to fp8 encoder: directed and random checks of all formats
module tb_fp32_to_fp8_encoder import f8e_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] value_bits;
	logic        target_format_we;
	logic [1:0]  target_format_wdata;
	logic        done;
	logic [7:0]  code;

	// Expected codes, oldest first
	logic [7:0] code_queue[$];
	fmt_t       fmt_model;
	int         error_count;
	int         sent_count;
	int         checked_count;
	int         send_idle_pct;

	fp32_to_fp8_encoder uut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.value_bits          (value_bits),
		.target_format_we    (target_format_we),
		.target_format_wdata (target_format_wdata),
		.done                (done),
		.code                (code)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Small-float encode for E4M3 (four exponent bits) or E5M2.
	// Round half away from zero; a carry out of the mantissa is clamped, never
	// propagated into the exponent.
	function automatic logic [7:0] small_float_code(logic sgn, logic [7:0] ex,
			logic [22:0] fr, bit is_e4m3);
		int unsigned mbits, bias, max_e, max_m, inf_c, mmax;
		int unsigned min_norm, min_sub, shift, q, ef;
		logic [7:0] s8;
		mbits    = is_e4m3 ? 3 : 2;
		bias     = is_e4m3 ? 7 : 15;
		max_e    = is_e4m3 ? 134 : 142;
		max_m    = is_e4m3 ? 32'h700000 : 32'h600000;
		inf_c    = is_e4m3 ? 32'h7E : 32'h7C;
		mmax     = (1 << mbits) - 1;
		min_norm = 128 - bias;
		min_sub  = min_norm - mbits;
		s8       = {sgn, 7'd0};
		if (ex == 8'hFF)
			return (fr != 0) ? 8'h7F : (s8 | 8'(inf_c));
		if (ex < min_sub)
			return s8;
		if (ex > max_e || (ex == max_e && fr > max_m))
			return s8 | 8'(inf_c);
		if (ex < min_norm) begin
			// Subnormal: shift the full significand into the mantissa field
			shift = 23 - (ex - min_sub);
			q = ((32'h800000 | fr) + (1 << (shift - 1))) >> shift;
			if (q < 1) q = 1;
			if (q > mmax) q = mmax;
			return s8 | 8'(q);
		end
		ef    = ex - 127 + bias;
		shift = 23 - mbits;
		q     = (fr + (1 << (shift - 1))) >> shift;
		if (q > mmax) q = mmax;
		return s8 | 8'((ef << mbits) | q);
	endfunction

	// Signed power of two, bias 63: round log2 by comparing the significand
	// with sqrt(2), clamp the exponent to the field.
	function automatic logic [7:0] pow2_code(logic sgn, logic [7:0] ex, logic [22:0] fr);
		int unsigned ef;
		if (ex == 8'hFF) return (fr != 0) ? 8'h00 : {sgn, 7'd0};
		if (ex < 64) return {sgn, 7'd0};
		if (ex >= 190) return {sgn, 7'd126};
		ef = ex - 64;
		if ((32'h800000 | fr) > 32'hB504F3) ef++;
		return {sgn, 7'(ef)};
	endfunction

	function automatic logic [7:0] predict_code(logic [31:0] x);
		case (fmt_model)
			FMT_E4M3: return small_float_code(x[31], x[30:23], x[22:0], 1'b1);
			FMT_E5M2: return small_float_code(x[31], x[30:23], x[22:0], 1'b0);
			FMT_E8M0: return pow2_code(x[31], x[30:23], x[22:0]);
			default:  return 8'h00;
		endcase
	endfunction

	// Send one value; idle first with the configured chance, then hold start
	// until the transfer edge. Leave start high; the next idle or drain drops it.
	task automatic send_value(logic [31:0] x);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		value_bits <= x;
		code_queue.push_back(predict_code(x));
		sent_count++;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Drop start and wait for all outstanding codes, then idle for a margin
	task automatic drain();
		start <= 1'b0;
		while (code_queue.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_format(fmt_t f);
		drain();
		target_format_we    <= 1'b1;
		target_format_wdata <= f;
		@(posedge clk);
		target_format_we <= 1'b0;
		fmt_model = f;
	endtask

	// Random value biased toward the interesting exponent band of each format
	function automatic logic [31:0] random_value();
		logic [31:0] x;
		x = $urandom;
		case ($urandom_range(9))
			0, 1, 2, 3: x[30:23] = 8'($urandom_range(105, 150));
			4:          x[30:23] = 8'($urandom_range(58, 70));
			5:          x[30:23] = 8'($urandom_range(185, 195));
			6:          x[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
			7:          x[22:0]  = {x[22:21], 21'h0FFFFF + 21'($urandom_range(2))};
			default: ;
		endcase
		return x;
	endfunction

	// Directed edges: specials, boundaries and rounding ties
	task automatic test_directed(fmt_t f);
		logic [31:0] vals[$];
		write_format(f);
		vals = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
			32'h7FC00000, 32'hFF800001, 32'h00000001, 32'h807FFFFF,
			32'h43700000, 32'h43700001, 32'h47600000, 32'h47600001,
			32'h3B000000, 32'h3A800000, 32'h37800000, 32'h37000000,
			32'h3F3504F3, 32'h3F3504F4, 32'hBFB504F4, 32'h1F800000,
			32'h5F000000, 32'h7F7FFFFF, 32'h3F880000, 32'h3C0C0000, 32'hFFFFFFFF};
		foreach (vals[i]) send_value(vals[i]);
	endtask

	task automatic test_random(int count, int idle_pct);
		send_idle_pct = idle_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) write_format(fmt_t'($urandom_range(3)));
			send_value(random_value());
		end
		send_idle_pct = 0;
	endtask

	// Check every strobed code against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (code_queue.size() == 0) begin
				$error("unexpected code %h", code);
				error_count++;
			end else begin
				if (code !== code_queue[0]) begin
					$error("code mismatch: expected %h actual %h", code_queue[0], code);
					error_count++;
				end
				void'(code_queue.pop_front());
				checked_count++;
			end
		end
	end

	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		error_count         = 0;
		sent_count          = 0;
		checked_count       = 0;
		send_idle_pct       = 0;
		fmt_model           = FMT_E4M3;
		arst_n              = 1'b0;
		start               = 1'b0;
		value_bits          = 32'd0;
		target_format_we    = 1'b0;
		target_format_wdata = 2'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Reset format is E4M3: exercise it before any write
		send_value(32'h43700000);
		test_directed(FMT_E4M3);
		test_directed(FMT_E5M2);
		test_directed(FMT_E8M0);
		test_directed(FMT_NONE);
		test_random(135, 15);
		test_random(135, 84);
		test_random(135, 0);
		drain();
		$display("Covered %0d values over all four format settings, %0d codes checked.",
			sent_count, checked_count);
		if (error_count == 0 && code_queue.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
